### src/multi_pattern_byte_matcher_assert.svh
// ----------------------------------------------------------------------------
// Multi-pattern byte matcher assertion macros
// Clocked property wrappers, empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef MULTI_PATTERN_BYTE_MATCHER_ASSERT_SVH
`define MULTI_PATTERN_BYTE_MATCHER_ASSERT_SVH
`ifndef SYNTHESIS
// Check that prop holds at every edge outside reset
`define MPBM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check that cond never holds outside reset
`define MPBM_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define MPBM_ASSERT(lbl, clk, rstn, prop, msg)
`define MPBM_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

### src/mpbm_pkg.sv
// ----------------------------------------------------------------------------
// mpbm_pkg
// Shared types and codes of the multi-pattern byte matcher.
// ----------------------------------------------------------------------------
package mpbm_pkg;

    localparam int MAX_PATTERNS_DEF = 16;
    localparam int MAX_LEN_DEF      = 15;

    localparam logic [1:0] CMD_DATA = 2'd0;
    localparam logic [1:0] CMD_PAT  = 2'd1;
    localparam logic [1:0] CMD_REM  = 2'd2;
    localparam logic [1:0] CMD_TAKE = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;
    localparam logic [1:0] ST_NONE  = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] value;
        logic       last;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [3:0]  hit_entry;
        logic [15:0] fired_mask;
        logic [15:0] pending_mask;
        logic [4:0]  pattern_count;
    } out_t;

endpackage

### src/mpbm_ifs.sv
// ----------------------------------------------------------------------------
// mpbm request channels
// Valid/ready channels for input requests and result requests.
// ----------------------------------------------------------------------------
interface mpbm_in_if
    import mpbm_pkg::*;
;
    logic valid;
    logic ready;
    in_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mpbm_out_if
    import mpbm_pkg::*;
;
    logic valid;
    logic ready;
    out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/mpbm_ram.sv
// ----------------------------------------------------------------------------
// mpbm_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mpbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 240,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/multi_pattern_byte_matcher.sv
// ----------------------------------------------------------------------------
// multi_pattern_byte_matcher
// Byte stream matcher against a table of patterns held in RAM.
//
//   channel  dir  payload                                   handshake
//   in_ch    in   cmd, value, last                          valid/ready
//   out_ch   out  status, hit, hit_entry, fired_mask,       valid/ready
//                 pending_mask, pattern_count
//
// One request at a time.
// Data byte: per entry, a RAM read of the next char, then of the first char
// on mismatch. Pattern char and take: no walk over the entries.
// Removal char: a RAM read per entry; the final char adds a search and,
// when an entry goes, the row copy of compaction, one RAM word per cycle.
// A result waiting on out_ch does not block the next request; a new result
// waits for the old one to drain. Reset clears all control state.
// ----------------------------------------------------------------------------
`include "multi_pattern_byte_matcher_assert.svh"

module multi_pattern_byte_matcher
    import mpbm_pkg::*;
#(
    parameter int MAX_PATTERNS = MAX_PATTERNS_DEF,
    parameter int MAX_LEN      = MAX_LEN_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    mpbm_in_if.sink          in_ch,
    mpbm_out_if.source       out_ch
);

    localparam int DEPTH = MAX_PATTERNS * MAX_LEN;
    localparam int RAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AW    = $clog2(DEPTH + 1);
    localparam int CW    = $clog2(MAX_PATTERNS + 1);
    localparam int IW    = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_DSET  = 4'd2;
    localparam logic [3:0] S_DCMP  = 4'd3;
    localparam logic [3:0] S_DFST  = 4'd4;
    localparam logic [3:0] S_RSET  = 4'd5;
    localparam logic [3:0] S_RCMP  = 4'd6;
    localparam logic [3:0] S_RFIND = 4'd7;
    localparam logic [3:0] S_COPY  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0]    state_reg, state_next;
    in_t           item_reg, item_next;
    logic [3:0]    len_reg [MAX_PATTERNS];
    logic [3:0]    len_next [MAX_PATTERNS];
    logic [3:0]    cnt_reg [MAX_PATTERNS];
    logic [3:0]    cnt_next [MAX_PATTERNS];
    logic [15:0]   pending_reg, pending_next;
    logic [CW-1:0] total_reg, total_next;
    logic [3:0]    build_reg, build_next;
    logic [15:0]   alive_reg, alive_next;
    logic [4:0]    rpos_reg, rpos_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [1:0]    status_reg, status_next;
    logic          hit_reg, hit_next;
    logic [3:0]    hent_reg, hent_next;
    logic [15:0]   fired_reg, fired_next;
    logic [AW-1:0] src_reg, src_next;
    logic [AW-1:0] end_reg, end_next;
    logic [AW-1:0] dst_reg, dst_next;
    logic          cpend_reg, cpend_next;
    out_t          out_reg, out_next;
    logic          ovalid_reg, ovalid_next;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    logic [IW-1:0] cur;
    logic [3:0]    cur_len, cur_cnt;
    logic [AW-1:0] cur_base, tot_base;

    assign cur      = idx_reg[IW-1:0];
    assign cur_len  = len_reg[cur];
    assign cur_cnt  = cnt_reg[cur];
    assign cur_base = AW'(idx_reg) * AW'(MAX_LEN);
    assign tot_base = AW'(total_reg) * AW'(MAX_LEN);

    mpbm_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_chars (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr[RAW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr[RAW-1:0]),
        .rdata (ram_rdata)
    );

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data  = out_reg;

    // Sequence one request through the table
    always_comb
    begin
        logic          found_ok;
        logic [CW-1:0] found;
        logic [15:0]   lmask;
        state_next  = state_reg;
        item_next   = item_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        pending_next = pending_reg;
        total_next  = total_reg;
        build_next  = build_reg;
        alive_next  = alive_reg;
        rpos_next   = rpos_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        hit_next    = hit_reg;
        hent_next   = hent_reg;
        fired_next  = fired_reg;
        src_next    = src_reg;
        end_next    = end_reg;
        dst_next    = dst_reg;
        cpend_next  = cpend_reg;
        out_next    = out_reg;
        ovalid_next = ovalid_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = '0;
        ram_raddr   = '0;
        ram_wdata   = '0;
        found_ok    = 1'b0;
        found       = '0;
        lmask       = '0;

        // Drop the result once taken
        if (ovalid_reg && out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    item_next  = in_ch.data;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                status_next = ST_OK;
                hit_next    = 1'b0;
                hent_next   = '0;
                fired_next  = '0;
                idx_next    = '0;
                case (item_reg.cmd)
                    CMD_DATA:
                    begin
                        state_next = (total_reg == '0) ? S_FIN : S_DSET;
                    end
                    CMD_PAT:
                    begin
                        state_next = S_FIN;
                        if (32'(total_reg) >= MAX_PATTERNS)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            if (item_reg.value != 8'd0)
                            begin
                                if (32'(build_reg) < MAX_LEN)
                                begin
                                    ram_we     = 1'b1;
                                    ram_waddr  = tot_base + AW'(build_reg);
                                    ram_wdata  = item_reg.value;
                                    build_next = build_reg + 4'd1;
                                end
                                else
                                begin
                                    status_next = ST_TRUNC;
                                end
                            end
                            if (item_reg.value == 8'd0 || item_reg.last)
                            begin
                                len_next[total_reg[IW-1:0]] = (ram_we) ? build_reg + 4'd1
                                                                       : build_reg;
                                cnt_next[total_reg[IW-1:0]] = 4'd0;
                                if (rpos_reg != 5'd0)
                                begin
                                    alive_next = alive_reg & ~(16'd1 << total_reg);
                                end
                                total_next = total_reg + CW'(1);
                                build_next = 4'd0;
                            end
                        end
                    end
                    CMD_REM:
                    begin
                        state_next = (item_reg.value != 8'd0) ? S_RSET : S_RFIND;
                    end
                    default:
                    begin
                        for (int i = 0; i < 16; i++)
                        begin
                            lmask[i] = (i < 32'(total_reg));
                        end
                        fired_next   = pending_reg & lmask;
                        pending_next = pending_reg & ~lmask;
                        state_next   = S_FIN;
                    end
                endcase
            end
            // Walk entries for a data byte
            S_DSET:
            begin
                if (idx_reg >= total_reg)
                begin
                    state_next = S_FIN;
                end
                else if (cur_len == 4'd0)
                begin
                    cnt_next[cur] = 4'd0;
                    idx_next      = idx_reg + CW'(1);
                end
                else if (cur_cnt < cur_len)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = cur_base + AW'(cur_cnt);
                    state_next = S_DCMP;
                end
                else if (cur_cnt != 4'd0)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = cur_base;
                    state_next = S_DFST;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_DCMP:
            begin
                if (ram_rdata == item_reg.value)
                begin
                    if (cur_cnt + 4'd1 == cur_len)
                    begin
                        cnt_next[cur] = 4'd0;
                        pending_next  = pending_reg | (16'd1 << idx_reg);
                        hit_next      = 1'b1;
                        hent_next     = 4'(idx_reg);
                        state_next    = S_FIN;
                    end
                    else
                    begin
                        cnt_next[cur] = cur_cnt + 4'd1;
                        idx_next      = idx_reg + CW'(1);
                        state_next    = S_DSET;
                    end
                end
                else if (cur_cnt != 4'd0)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = cur_base;
                    state_next = S_DFST;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_DSET;
                end
            end
            S_DFST:
            begin
                cnt_next[cur] = (ram_rdata == item_reg.value) ? 4'd1 : 4'd0;
                idx_next      = idx_reg + CW'(1);
                state_next    = S_DSET;
            end
            // Walk entries for a removal char
            S_RSET:
            begin
                if (idx_reg >= total_reg)
                begin
                    if (rpos_reg != 5'd31)
                    begin
                        rpos_next = rpos_reg + 5'd1;
                    end
                    state_next = item_reg.last ? S_RFIND : S_FIN;
                end
                else if (rpos_reg < {1'b0, cur_len})
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = cur_base + AW'(rpos_reg[3:0]);
                    state_next = S_RCMP;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_RCMP:
            begin
                if (ram_rdata != item_reg.value)
                begin
                    alive_next = alive_reg & ~(16'd1 << idx_reg);
                end
                idx_next   = idx_reg + CW'(1);
                state_next = S_RSET;
            end
            // Pick the first surviving prefix and compact
            S_RFIND:
            begin
                for (int i = MAX_PATTERNS - 1; i >= 0; i--)
                begin
                    if (alive_reg[i] && i < 32'(total_reg) && 5'(len_reg[i]) <= rpos_reg)
                    begin
                        found_ok = 1'b1;
                        found    = CW'(i);
                    end
                end
                alive_next = '1;
                rpos_next  = 5'd0;
                if (!found_ok)
                begin
                    status_next = ST_NONE;
                    state_next  = S_FIN;
                end
                else
                begin
                    for (int j = 0; j < MAX_PATTERNS - 1; j++)
                    begin
                        if (CW'(j) >= found && 32'(j) + 1 < 32'(total_reg))
                        begin
                            len_next[j] = len_reg[j+1];
                            cnt_next[j] = cnt_reg[j+1];
                        end
                    end
                    total_next = total_reg - CW'(1);
                    src_next   = AW'(found) * AW'(MAX_LEN) + AW'(MAX_LEN);
                    end_next   = tot_base;
                    cpend_next = 1'b0;
                    state_next = S_COPY;
                end
            end
            // Move rows down one word per cycle
            S_COPY:
            begin
                if (cpend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = dst_reg;
                    ram_wdata = ram_rdata;
                end
                if (src_reg < end_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = src_reg;
                    dst_next   = src_reg - AW'(MAX_LEN);
                    src_next   = src_reg + AW'(1);
                    cpend_next = 1'b1;
                end
                else
                begin
                    cpend_next = 1'b0;
                    if (!cpend_reg)
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            // Hold until the result register is free
            S_FIN:
            begin
                if (!ovalid_reg || out_ch.ready)
                begin
                    out_next.status        = status_reg;
                    out_next.hit           = hit_reg;
                    out_next.hit_entry     = hent_reg;
                    out_next.fired_mask    = fired_reg;
                    out_next.pending_mask  = pending_reg;
                    out_next.pattern_count = 5'(total_reg);
                    ovalid_next            = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pending_reg <= '0;
            total_reg   <= '0;
            build_reg   <= '0;
            alive_reg   <= '1;
            rpos_reg    <= '0;
            idx_reg     <= '0;
            cpend_reg   <= 1'b0;
            ovalid_reg  <= 1'b0;
            for (int i = 0; i < MAX_PATTERNS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            total_reg   <= total_next;
            build_reg   <= build_next;
            alive_reg   <= alive_next;
            rpos_reg    <= rpos_next;
            idx_reg     <= idx_next;
            cpend_reg   <= cpend_next;
            ovalid_reg  <= ovalid_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        len_reg    <= len_next;
        status_reg <= status_next;
        hit_reg    <= hit_next;
        hent_reg   <= hent_next;
        fired_reg  <= fired_next;
        src_reg    <= src_next;
        end_reg    <= end_next;
        dst_reg    <= dst_next;
        out_reg    <= out_next;
    end

    `MPBM_ASSERT_NEVER(a_total_range, clk, rst_n, 32'(total_reg) > MAX_PATTERNS, "entry total overflow")
    `MPBM_ASSERT(a_rise_from_fin, clk, rst_n, $rose(ovalid_reg) |-> $past(state_reg == S_FIN), "result without finish")
    `MPBM_ASSERT(a_write_owner, clk, rst_n, ram_we |-> (state_reg == S_START || state_reg == S_COPY), "stray RAM write")
    `MPBM_ASSERT(a_read_range, clk, rst_n, ram_re |-> 32'(ram_raddr) < DEPTH, "RAM read out of range")

endmodule

### dv/mpbm_tb_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench channel note
// The request channels come from the RTL interface file; this file holds the
// testbench-side request record used by the stimulus queue and the driver.
// ----------------------------------------------------------------------------
package mpbm_tb_pkg;
    import mpbm_pkg::*;

    // One stimulus request with its sender gap
    typedef struct {
        in_t req;
        int  gap;
        bit  drain;
    } stim_t;
endpackage

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-pattern byte matcher testbench
// Streams pattern builds, removal strings, data bytes and take requests into
// the matcher, predicts every result with a cycle-free table model and
// compares each result field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
    import mpbm_pkg::*;
    import mpbm_tb_pkg::*;

    localparam int NPAT = 16;
    localparam int NLEN = 15;

    logic clk;
    logic rst_n;

    mpbm_in_if  in_ch ();
    mpbm_out_if out_ch ();

    multi_pattern_byte_matcher dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // Predictor state
    logic [7:0]  tbl_chars [NPAT][NLEN];
    logic [3:0]  tbl_len [NPAT];
    logic [3:0]  tbl_prog [NPAT];
    logic [15:0] pend;
    int          n_ent;
    int          bld_pos;
    logic [15:0] rm_alive;
    int          rm_pos;

    stim_t pending_reqs[$];
    out_t  expected_results[$];
    int    errors;
    int    n_hits;
    int    n_removed;

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Predict the result of one request and advance the table state
    function automatic out_t predict_match(in_t r);
        out_t o;
        int i;
        int j;
        int found;
        int cnt;
        o = '0;
        case (r.cmd)
            CMD_DATA:
            begin
                for (i = 0; i < n_ent; i++)
                begin
                    cnt = tbl_prog[i];
                    if (tbl_len[i] == 0)
                    begin
                        tbl_prog[i] = 4'd0;
                        continue;
                    end
                    if (cnt < tbl_len[i] && r.value == tbl_chars[i][cnt])
                    begin
                        cnt++;
                        if (cnt == tbl_len[i])
                        begin
                            tbl_prog[i] = 4'd0;
                            pend[i] = 1'b1;
                            o.hit = 1'b1;
                            o.hit_entry = i[3:0];
                            break;
                        end
                        tbl_prog[i] = cnt[3:0];
                    end
                    else if (cnt > 0)
                    begin
                        tbl_prog[i] = (r.value == tbl_chars[i][0]) ? 4'd1 : 4'd0;
                    end
                end
            end
            CMD_PAT:
            begin
                if (n_ent >= NPAT)
                begin
                    o.status = ST_FULL;
                end
                else
                begin
                    if (r.value != 0)
                    begin
                        if (bld_pos < NLEN)
                        begin
                            tbl_chars[n_ent][bld_pos] = r.value;
                            bld_pos++;
                        end
                        else
                        begin
                            o.status = ST_TRUNC;
                        end
                    end
                    if (r.value == 0 || r.last)
                    begin
                        tbl_len[n_ent] = bld_pos[3:0];
                        tbl_prog[n_ent] = 4'd0;
                        if (rm_pos != 0)
                            rm_alive[n_ent] = 1'b0;
                        n_ent++;
                        bld_pos = 0;
                    end
                end
            end
            CMD_REM:
            begin
                if (r.value != 0)
                begin
                    for (i = 0; i < n_ent; i++)
                    begin
                        if (rm_pos < tbl_len[i] && tbl_chars[i][rm_pos] != r.value)
                            rm_alive[i] = 1'b0;
                    end
                    if (rm_pos < 31)
                        rm_pos++;
                end
                if (r.value == 0 || r.last)
                begin
                    found = NPAT;
                    for (i = 0; i < n_ent; i++)
                    begin
                        if (rm_alive[i] && tbl_len[i] <= rm_pos)
                        begin
                            found = i;
                            break;
                        end
                    end
                    rm_alive = 16'hFFFF;
                    rm_pos = 0;
                    if (found >= n_ent)
                    begin
                        o.status = ST_NONE;
                    end
                    else
                    begin
                        // Compact rows; pending bits stay in place
                        for (j = found; j + 1 < n_ent; j++)
                        begin
                            tbl_chars[j] = tbl_chars[j + 1];
                            tbl_len[j] = tbl_len[j + 1];
                            tbl_prog[j] = tbl_prog[j + 1];
                        end
                        n_ent--;
                        n_removed++;
                    end
                end
            end
            default:
            begin
                o.fired_mask = pend & ((17'd1 << n_ent) - 17'd1);
                pend = pend & ~o.fired_mask;
            end
        endcase
        o.pending_mask = pend;
        o.pattern_count = n_ent[4:0];
        return o;
    endfunction

    function automatic void push_req(logic [1:0] c, logic [7:0] v, logic l, bit drain = 0);
        stim_t s;
        s.req.cmd = c;
        s.req.value = v;
        s.req.last = l;
        s.gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        s.drain = drain;
        pending_reqs.push_back(s);
    endfunction

    // Stream a string; zero-terminated or marked last on the final char
    function automatic void push_string(logic [1:0] c, logic [7:0] s[$], bit use_zero);
        int k;
        for (k = 0; k < s.size(); k++)
            push_req(c, s[k], (!use_zero && k == s.size() - 1));
        if (use_zero || s.size() == 0)
            push_req(c, 8'd0, 1'($urandom_range(0, 1)));
    endfunction

    // Reporting
    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // Driver: change inputs at falling edge
    int drv_wait;
    int n_sent = 0;
    int n_acc = 0;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            drv_wait = 0;
        end
        else if (!(in_ch.valid && n_acc != n_sent))
        begin
            // Previous request either accepted or none in flight
            if (pending_reqs.size() > 0)
            begin
                if (pending_reqs[0].drain && expected_results.size() > 0)
                begin
                    in_ch.valid <= 1'b0;
                end
                else if (drv_wait < pending_reqs[0].gap)
                begin
                    drv_wait++;
                    in_ch.valid <= 1'b0;
                end
                else
                begin
                    in_ch.data <= pending_reqs[0].req;
                    in_ch.valid <= 1'b1;
                    n_sent++;
                    drv_wait = 0;
                end
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Accept requests and predict at rising edge
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            expected_results.push_back(predict_match(in_ch.data));
            void'(pending_reqs.pop_front());
            n_acc++;
        end
    end

    // Result sink stall pattern
    int snk_wait;
    int snk_gap;
    int snk_seen;
    int n_out = 0;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            snk_wait = 0;
            snk_gap = 0;
            snk_seen = 0;
        end
        else if (snk_seen != n_out)
        begin
            // A result was taken: draw the idle time before the next
            snk_seen = n_out;
            snk_wait = 0;
            snk_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            out_ch.ready <= (snk_gap == 0);
        end
        else if (snk_wait >= snk_gap)
        begin
            out_ch.ready <= 1'b1;
        end
        else
        begin
            snk_wait++;
            out_ch.ready <= 1'b0;
        end
    end

    // Monitor: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        out_t g;
        out_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            g = out_ch.data;
            n_out++;
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result", int'(g), 0);
            end
            else
            begin
                e = expected_results.pop_front();
                if (g.hit) n_hits++;
                if (g.status !== e.status) report_mismatch("status", g.status, e.status);
                if (g.hit !== e.hit) report_mismatch("hit", g.hit, e.hit);
                if (g.hit_entry !== e.hit_entry)
                    report_mismatch("hit_entry", g.hit_entry, e.hit_entry);
                if (g.fired_mask !== e.fired_mask)
                    report_mismatch("fired_mask", g.fired_mask, e.fired_mask);
                if (g.pending_mask !== e.pending_mask)
                    report_mismatch("pending_mask", g.pending_mask, e.pending_mask);
                if (g.pattern_count !== e.pattern_count)
                    report_mismatch("pattern_count", g.pattern_count, e.pattern_count);
            end
        end
    end

    // Random string over a small alphabet so matches happen often
    function automatic void rand_str(ref logic [7:0] s[$], input int maxlen);
        int n;
        int k;
        s.delete();
        n = $urandom_range(0, maxlen);
        for (k = 0; k < n; k++)
            s.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255))
                                                    : 8'($urandom_range(8'h61, 8'h64)));
    endfunction

    // Stimulus
    initial
    begin
        logic [7:0] s[$];
        int k;
        int m;
        int kind;
        errors = 0;
        n_hits = 0;
        n_removed = 0;
        pend = '0;
        n_ent = 0;
        bld_pos = 0;
        rm_alive = 16'hFFFF;
        rm_pos = 0;
        for (k = 0; k < NPAT; k++)
        begin
            tbl_prog[k] = 4'd0;
            tbl_len[k] = 4'd0;
        end
        rst_n = 1'b0;

        // Directed: take and data with an empty table
        push_req(CMD_TAKE, 8'hFF, 1'b1);
        push_req(CMD_DATA, 8'h00, 1'b0);
        push_req(CMD_DATA, 8'hFF, 1'b1);
        // Empty pattern, short pattern, long pattern with truncation
        push_req(CMD_PAT, 8'h00, 1'b0);
        s = '{8'h61, 8'h62};
        push_string(CMD_PAT, s, 0);
        s.delete();
        for (k = 0; k < 17; k++) s.push_back(8'(8'h80 + k));
        push_string(CMD_PAT, s, 1);
        // Data hitting, then take, then removal matching and missing
        push_req(CMD_DATA, 8'h61, 1'b0);
        push_req(CMD_DATA, 8'h62, 1'b0);
        push_req(CMD_TAKE, 8'h00, 1'b0);
        s = '{8'hFF, 8'h01};
        push_string(CMD_REM, s, 0);
        s = '{8'h61, 8'h62, 8'h63};
        push_string(CMD_REM, s, 1);
        push_req(CMD_REM, 8'h00, 1'b1, 1);

        // Random phases: mostly pattern builds, data bursts and removals
        m = 0;
        while (m < 1420)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 1)
            begin
                rand_str(s, ($urandom_range(0, 9) == 0) ? 18 : 4);
                push_string(CMD_PAT, s, 1'($urandom_range(0, 1)));
                m += s.size() + 1;
            end
            else if (kind <= 6)
            begin
                for (k = 0; k < 12; k++)
                    push_req(CMD_DATA, ($urandom_range(0, 5) == 0) ? 8'($urandom)
                                       : 8'($urandom_range(8'h61, 8'h64)),
                             1'($urandom_range(0, 1)));
                m += 12;
            end
            else if (kind == 7)
            begin
                rand_str(s, 5);
                push_string(CMD_REM, s, 1'($urandom_range(0, 1)));
                m += s.size() + 1;
            end
            else if (kind == 8)
            begin
                push_req(CMD_TAKE, 8'($urandom), 1'($urandom_range(0, 1)));
                m++;
            end
            else
            begin
                // Build a pattern while removal is in flight
                rand_str(s, 3);
                for (k = 0; k < s.size(); k++)
                    push_req(CMD_REM, s[k], 1'b0);
                push_req(CMD_PAT, 8'h62, 1'b1);
                push_req(CMD_REM, 8'h00, 1'b0);
                m += s.size() + 2;
            end
            if (m > 700 && m < 720)
                push_req(CMD_TAKE, 8'h00, 1'b0, 1);
        end
        // Long removal string to saturate the position counter
        for (k = 0; k < 34; k++)
            push_req(CMD_REM, 8'h61, 1'b0);
        push_req(CMD_REM, 8'h00, 1'b0);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_reqs.size() == 0);
        wait (expected_results.size() == 0);
        repeat (100) @(posedge clk);
        $display("Run covered pattern builds, removals, takes and data; %0d hits, %0d removals.",
                 n_hits, n_removed);
        if (errors == 0 && expected_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Timeout
    initial
    begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
